// ----- src/terminal_byte_line_parser_macros.svh -----
// Assertion macros for the terminal byte line parser.
// Each macro samples on clk_i and is disabled while rst_ni is low.
// Define NO_ASSERTIONS to compile every use to nothing.
`ifndef TERMINAL_BYTE_LINE_PARSER_MACROS_SVH
`define TERMINAL_BYTE_LINE_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TBLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define TBLP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`else

`define TBLP_ASSERT(label, prop, msg)

`define TBLP_ASSERT_NEXT(label, cond, prop, msg)

`endif

`endif

// ----- src/tblp_pkg.sv -----
// Shared codes and types of the terminal byte line parser.
// No dependencies; imported by the parser top level.
package tblp_pkg;

  localparam logic [2:0] PS_IDLE       = 3'd0;
  localparam logic [2:0] PS_MOD_KEEP   = 3'd1;
  localparam logic [2:0] PS_MOD_DROP   = 3'd2;
  localparam logic [2:0] PS_KEY_KEEP   = 3'd3;
  localparam logic [2:0] PS_KEY_DROP   = 3'd4;
  localparam logic [2:0] PS_OPT_FIRST  = 3'd5;
  localparam logic [2:0] PS_OPT_SECOND = 3'd6;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_KEY  = 3'd1;
  localparam logic [2:0] EV_LINE = 3'd2;
  localparam logic [2:0] EV_LONG = 3'd3;
  localparam logic [2:0] EV_READ = 3'd4;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] CH_KEY_FRAME  = 8'd239;
  localparam logic [7:0] CH_DROP_FRAME = 8'd238;
  localparam logic [7:0] CH_IAC        = 8'd255;
  localparam logic [7:0] CH_DEL        = 8'd127;
  localparam logic [7:0] CH_BS         = 8'd8;
  localparam logic [7:0] CH_CR         = 8'd13;
  localparam logic [7:0] CH_LF         = 8'd10;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_TILDE      = 8'd126;

  localparam logic [7:0] EXIT_WORD [4] = '{8'h65, 8'h78, 8'h69, 8'h74};

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] key_modifier;
    logic [7:0] key_code;
    logic [7:0] line_length;
    logic       line_is_exit;
    logic       rd_ok;
  } tblp_res_t;

endpackage

// ----- src/tblp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tblp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/terminal_byte_line_parser.sv -----
// Terminal byte line parser: per-slot key frame, option and line editing.
// A request passes stage register s1_q, then the result register; throughput 1 request per cycle
// unless out_stall_i holds a result. The RAM read (registered) lands beside s1_q; the stage
// ahead of the result register takes one more request while a result waits. Reset is asynchronous,
// active low, and clears parser state, line counts and valid flags; line store stays undefined.
// Depends on tblp_pkg, tblp_ram and terminal_byte_line_parser_macros.svh.
`include "terminal_byte_line_parser_macros.svh"

module terminal_byte_line_parser
  import tblp_pkg::*;
#(
  parameter int unsigned LINE_CAPACITY = 128,
  parameter int unsigned SLOT_COUNT    = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic       slot_i,
  input  logic [7:0] data_byte_i,
  input  logic [6:0] read_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] event_res_o,
  output logic [7:0] key_modifier_o,
  output logic [7:0] key_code_o,
  output logic [7:0] line_length_o,
  output logic       line_is_exit_o,
  output logic [7:0] read_char_o
);

  localparam int unsigned DEPTH = SLOT_COUNT * LINE_CAPACITY;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(LINE_CAPACITY + 1);
  localparam int unsigned SIW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [2:0]    ps_q    [SLOT_COUNT];
  logic [2:0]    ps_d    [SLOT_COUNT];
  logic [7:0]    hm_q    [SLOT_COUNT];
  logic [7:0]    hm_d    [SLOT_COUNT];
  logic [CW-1:0] cnt_q   [SLOT_COUNT];
  logic [CW-1:0] cnt_d   [SLOT_COUNT];
  logic [3:0]    flags_q [SLOT_COUNT];
  logic [3:0]    flags_d [SLOT_COUNT];

  logic          in_acc;
  logic          s1_adv;
  logic          s1_valid_q, s1_valid_d;
  logic          out_valid_q, out_valid_d;
  tblp_res_t     res_d, s1_q;

  logic          slot_ok;
  logic [SIW-1:0] sidx;
  logic [2:0]    ps;
  logic [CW-1:0] cnt;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_adv     = !out_valid_q || !out_stall_i;

  assign slot_ok = 32'(slot_i) < SLOT_COUNT;
  assign sidx    = SIW'(slot_i);
  assign ps      = ps_q[sidx];
  assign cnt     = cnt_q[sidx];

  always_comb begin
    ps_d      = ps_q;
    hm_d      = hm_q;
    cnt_d     = cnt_q;
    flags_d   = flags_q;
    res_d     = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = AW'(32'(sidx) * LINE_CAPACITY + 32'(cnt));
    ram_raddr = AW'(32'(sidx) * LINE_CAPACITY + 32'(read_index_i));
    if (in_acc && slot_ok) begin
      if (op_i == OP_READ) begin
        res_d.event_res = EV_READ;
        res_d.rd_ok     = 32'(read_index_i) < LINE_CAPACITY;
        ram_re          = res_d.rd_ok;
      end else begin
        unique case (ps) inside
          PS_MOD_KEEP, PS_MOD_DROP: begin
            hm_d[sidx] = data_byte_i;
            ps_d[sidx] = (ps == PS_MOD_KEEP) ? PS_KEY_KEEP : PS_KEY_DROP;
          end
          PS_KEY_KEEP: begin
            res_d.event_res    = EV_KEY;
            res_d.key_modifier = hm_q[sidx];
            res_d.key_code     = data_byte_i;
            ps_d[sidx]         = PS_IDLE;
          end
          PS_KEY_DROP: begin
            ps_d[sidx] = PS_IDLE;
          end
          default: begin
            if (data_byte_i == CH_KEY_FRAME) begin
              ps_d[sidx] = PS_MOD_KEEP;
            end else if (data_byte_i == CH_DROP_FRAME) begin
              ps_d[sidx] = PS_MOD_DROP;
            end else if (ps == PS_OPT_FIRST) begin
              ps_d[sidx] = PS_OPT_SECOND;
            end else if (ps == PS_OPT_SECOND) begin
              ps_d[sidx] = PS_IDLE;
            end else begin
              ps_d[sidx] = PS_IDLE;
              if (data_byte_i == CH_IAC) begin
                ps_d[sidx] = PS_OPT_FIRST;
              end else if (data_byte_i == CH_LF) begin
                ps_d[sidx] = PS_IDLE;
              end else if (data_byte_i == CH_CR) begin
                res_d.event_res    = EV_LINE;
                res_d.line_length  = 8'(cnt);
                res_d.line_is_exit = (cnt == CW'(4)) && (&flags_q[sidx]);
                cnt_d[sidx]        = '0;
              end else if (data_byte_i == CH_BS || data_byte_i == CH_DEL) begin
                if (cnt != '0) begin
                  cnt_d[sidx] = cnt - CW'(1);
                end
              end else if (data_byte_i >= CH_SPACE && data_byte_i <= CH_TILDE) begin
                if (cnt < CW'(LINE_CAPACITY)) begin
                  ram_we      = 1'b1;
                  cnt_d[sidx] = cnt + CW'(1);
                  if (cnt < CW'(4)) begin
                    flags_d[sidx][cnt[1:0]] = (data_byte_i == EXIT_WORD[cnt[1:0]]);
                  end
                end else begin
                  cnt_d[sidx]     = '0;
                  res_d.event_res = EV_LONG;
                end
              end
            end
          end
        endcase
      end
    end
  end

  tblp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
      s1_valid_d  = 1'b0;
    end
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        ps_q[i]    <= PS_IDLE;
        hm_q[i]    <= '0;
        cnt_q[i]   <= '0;
        flags_q[i] <= '0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      ps_q        <= ps_d;
      hm_q        <= hm_d;
      cnt_q       <= cnt_d;
      flags_q     <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= res_d;
    end
    if (s1_adv && s1_valid_q) begin
      event_res_o    <= s1_q.event_res;
      key_modifier_o <= s1_q.key_modifier;
      key_code_o     <= s1_q.key_code;
      line_length_o  <= s1_q.line_length;
      line_is_exit_o <= s1_q.line_is_exit;
      read_char_o    <= s1_q.rd_ok ? ram_rdata : 8'd0;
    end
  end

  assign out_valid_o = out_valid_q;

  `TBLP_ASSERT(a_stall_needs_s1, in_stall_o |-> s1_valid_q, "input stall without held request")
  `TBLP_ASSERT(a_ram_one_port, !(ram_we && ram_re), "line store written and read by one request")
  `TBLP_ASSERT(a_count_bound, cnt_q[0] <= CW'(LINE_CAPACITY), "line count beyond capacity")
  `TBLP_ASSERT_NEXT(a_read_tracked, in_acc && op_i == OP_READ && slot_ok,
    s1_valid_q && s1_q.event_res == EV_READ, "read request lost before result stage")

endmodule
